// ===== hw/rtl/drsp_pkg.sv =====
// ----------------------------------------------------------------------------
// drsp_pkg
// Shared types and constants for the daylight-saving rule string parser.
// ----------------------------------------------------------------------------
package drsp_pkg;

    localparam logic [7:0]  CH_NUL    = 8'h00;
    localparam logic [7:0]  CH_LPAREN = 8'h28;
    localparam logic [7:0]  CH_RPAREN = 8'h29;
    localparam logic [7:0]  CH_PLUS   = 8'h2B;
    localparam logic [7:0]  CH_MINUS  = 8'h2D;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_SIX    = 8'h36;
    localparam logic [7:0]  CH_NINE   = 8'h39;

    localparam logic [13:0] YEAR_BASE  = 14'd1900;
    localparam logic [6:0]  MONTH_MAX  = 7'd12;
    localparam logic [3:0]  SUNDAY     = 4'd7;
    localparam logic [3:0]  WDAY_AFTER = 4'd7;
    localparam logic [1:0]  YEAR_LAST_DIGIT = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [3:0] {
        PH_WAIT   = 4'd0,
        PH_START  = 4'd1,
        PH_YEAR   = 4'd2,
        PH_YCLOSE = 4'd3,
        PH_MON1   = 4'd4,
        PH_MON2   = 4'd5,
        PH_DAY1   = 4'd6,
        PH_DAY2   = 4'd7,
        PH_AFTDAY = 4'd8,
        PH_HOUR2  = 4'd9,
        PH_TAIL   = 4'd10,
        PH_WDAY   = 4'd11,
        PH_END    = 4'd12,
        PH_SKIP   = 4'd13
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ERROR = 2'd1,
        ACT_CLOSE = 2'd2
    } act_t;

    typedef struct packed {
        logic        status;
        logic [12:0] year_offset;
        logic [3:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [3:0]  weekday_rule;
        logic        last;
    } rec_t;

endpackage

// ===== hw/rtl/drsp_parse.sv =====
// ----------------------------------------------------------------------------
// drsp_parse
// Per-byte rule parser: phase register, field registers and record build.
// ----------------------------------------------------------------------------
module drsp_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         ch,
    output logic               emit,
    output drsp_pkg::rec_t     rec
);
    import drsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  delim_reg, delim_next;
    logic [12:0] year_reg, year_next;
    logic [13:0] accum_reg, accum_next;
    logic [1:0]  count_reg, count_next;
    logic [3:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [3:0]  wday_reg, wday_next;
    logic        after_reg, after_next;

    act_t        act;
    logic        is_dig;
    logic        is_sign;
    logic        is_wday;
    logic        closes;
    logic [3:0]  dig;
    logic [13:0] year_val;
    logic [6:0]  pair_val;
    logic [3:0]  wday_val;

    assign dig      = ch[3:0];
    assign is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign is_wday  = (ch >= CH_ZERO) && (ch <= CH_SIX);
    assign closes   = (ch == CH_NUL) || (ch == delim_reg);
    // x*10 as shifts and an add
    assign year_val = (accum_reg << 3) + (accum_reg << 1) + 14'(dig);
    assign pair_val = (7'(accum_reg[3:0]) << 3) + (7'(accum_reg[3:0]) << 1) + 7'(dig);
    assign wday_val = ((dig == 4'd0) ? SUNDAY : dig) + (after_reg ? WDAY_AFTER : 4'd0);

    // what this byte does to the record stream
    always_comb
    begin
        act = ACT_NONE;
        unique case (phase_reg)
            PH_WAIT:   if (ch == CH_NUL) act = ACT_ERROR;
            PH_START:  if (ch != CH_LPAREN && !is_dig) act = ACT_ERROR;
            PH_YEAR:
            begin
                if (!is_dig)
                    act = ACT_ERROR;
                else if (count_reg == YEAR_LAST_DIGIT && year_val < YEAR_BASE)
                    act = ACT_ERROR;
            end
            PH_YCLOSE: if (ch != CH_RPAREN) act = ACT_ERROR;
            PH_MON1:   if (!is_dig) act = ACT_ERROR;
            PH_MON2:
                if (!is_dig || pair_val == 7'd0 || pair_val > MONTH_MAX) act = ACT_ERROR;
            PH_DAY1:   if (!is_dig) act = ACT_ERROR;
            PH_DAY2:   if (!is_dig || pair_val == 7'd0) act = ACT_ERROR;
            PH_AFTDAY:
                if (!is_dig && !is_sign) act = closes ? ACT_CLOSE : ACT_ERROR;
            PH_HOUR2:  if (!is_dig) act = ACT_ERROR;
            PH_TAIL:   if (!is_sign) act = closes ? ACT_CLOSE : ACT_ERROR;
            PH_WDAY:   if (!is_wday) act = ACT_ERROR;
            PH_END:    act = closes ? ACT_CLOSE : ACT_ERROR;
            default:   act = ACT_NONE;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        delim_next = delim_reg;
        year_next  = year_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        month_next = month_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        wday_next  = wday_reg;
        after_next = after_reg;
        if (act == ACT_ERROR)
        begin
            phase_next = (ch == CH_NUL) ? PH_WAIT : PH_SKIP;
        end
        else if (act == ACT_CLOSE && ch == CH_NUL)
        begin
            phase_next = PH_WAIT;
        end
        else if (act == ACT_CLOSE || phase_reg == PH_WAIT)
        begin
            // start of a new rule
            if (phase_reg == PH_WAIT)
            begin
                delim_next = ch;
                year_next  = 13'd0;
            end
            phase_next = PH_START;
            accum_next = 14'd0;
            count_next = 2'd0;
            month_next = 4'd0;
            day_next   = 7'd0;
            hour_next  = 7'd0;
            wday_next  = 4'd0;
            after_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (ch == CH_LPAREN)
                    begin
                        accum_next = 14'd0;
                        count_next = 2'd0;
                        phase_next = PH_YEAR;
                    end
                    else
                    begin
                        accum_next = 14'(dig);
                        phase_next = PH_MON2;
                    end
                end
                PH_YEAR:
                begin
                    accum_next = year_val;
                    if (count_reg == YEAR_LAST_DIGIT)
                    begin
                        year_next  = 13'(year_val - YEAR_BASE);
                        count_next = 2'd0;
                        phase_next = PH_YCLOSE;
                    end
                    else
                    begin
                        count_next = count_reg + 2'd1;
                    end
                end
                PH_YCLOSE: phase_next = PH_MON1;
                PH_MON1:
                begin
                    accum_next = 14'(dig);
                    phase_next = PH_MON2;
                end
                PH_MON2:
                begin
                    month_next = 4'(pair_val - 7'd1);
                    phase_next = PH_DAY1;
                end
                PH_DAY1:
                begin
                    accum_next = 14'(dig);
                    phase_next = PH_DAY2;
                end
                PH_DAY2:
                begin
                    day_next   = pair_val - 7'd1;
                    phase_next = PH_AFTDAY;
                end
                PH_AFTDAY:
                begin
                    if (is_dig)
                    begin
                        accum_next = 14'(dig);
                        phase_next = PH_HOUR2;
                    end
                    else
                    begin
                        after_next = (ch == CH_PLUS);
                        phase_next = PH_WDAY;
                    end
                end
                PH_HOUR2:
                begin
                    hour_next  = pair_val;
                    phase_next = PH_TAIL;
                end
                PH_TAIL:
                begin
                    after_next = (ch == CH_PLUS);
                    phase_next = PH_WDAY;
                end
                PH_WDAY:
                begin
                    wday_next  = wday_val;
                    phase_next = PH_END;
                end
                default:
                begin
                    if (ch == CH_NUL)
                        phase_next = PH_WAIT;
                end
            endcase
        end
    end

    // record outputs
    always_comb
    begin
        emit = (act != ACT_NONE);
        rec.last = (ch == CH_NUL);
        if (act == ACT_CLOSE)
        begin
            rec.status       = STATUS_OK;
            rec.year_offset  = year_reg;
            rec.month        = month_reg;
            rec.day          = day_reg;
            rec.hour         = hour_reg;
            rec.weekday_rule = wday_reg;
        end
        else
        begin
            rec.status       = STATUS_ERR;
            rec.year_offset  = 13'd0;
            rec.month        = 4'd0;
            rec.day          = 7'd0;
            rec.hour         = 7'd0;
            rec.weekday_rule = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            delim_reg <= 8'd0;
            year_reg  <= 13'd0;
            accum_reg <= 14'd0;
            count_reg <= 2'd0;
            month_reg <= 4'd0;
            day_reg   <= 7'd0;
            hour_reg  <= 7'd0;
            wday_reg  <= 4'd0;
            after_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            delim_reg <= delim_next;
            year_reg  <= year_next;
            accum_reg <= accum_next;
            count_reg <= count_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            hour_reg  <= hour_next;
            wday_reg  <= wday_next;
            after_reg <= after_next;
        end
    end

endmodule

// ===== hw/rtl/dst_rule_string_parser_core.sv =====
// ----------------------------------------------------------------------------
// dst_rule_string_parser_core
// Byte input register, rule parser and record output register.
// ----------------------------------------------------------------------------
// a record's closing byte is accepted into the input register, and the record is
// then written to the record register, which drives the outputs
// throughput: one byte per cycle; a byte that makes a record waits only while
// the record register is full and not being drained
// reset: parser returns to waiting for a delimiter, year qualifier cleared,
// both registers empty
module dst_rule_string_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [12:0] year_offset,
    output logic [3:0]  month,
    output logic [6:0]  day,
    output logic [6:0]  hour,
    output logic [3:0]  weekday_rule,
    output logic        last
);
    import drsp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       out_valid_reg;
    rec_t       rec_reg;
    rec_t       rec;
    logic       emit;
    logic       advance;

    drsp_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .ch    (ch_reg),
        .emit  (emit),
        .rec   (rec)
    );

    // a byte moves on unless its record has nowhere to go
    assign advance  = in_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ch_reg <= ch;
        if (advance && emit)
            rec_reg <= rec;
    end

    assign out_valid    = out_valid_reg;
    assign status       = rec_reg.status;
    assign year_offset  = rec_reg.year_offset;
    assign month        = rec_reg.month;
    assign day          = rec_reg.day;
    assign hour         = rec_reg.hour;
    assign weekday_rule = rec_reg.weekday_rule;
    assign last         = rec_reg.last;

endmodule
